FILE: rtl/ltch_pkg.sv
package ltch_pkg;

    localparam int MAX_POINTS = 1024;
    localparam int AW = $clog2(MAX_POINTS);
    localparam int CW = AW + 1;

    typedef logic signed [15:0] t_coord;

    typedef struct packed {
        t_coord x;
        t_coord y;
    } t_point;

    // Operation codes from the controller to the datapath.
    localparam logic [3:0] OP_NONE   = 4'd0;
    localparam logic [3:0] OP_LOAD   = 4'd1;
    localparam logic [3:0] OP_RDA    = 4'd2;
    localparam logic [3:0] OP_RDB    = 4'd3;
    localparam logic [3:0] OP_WRPS   = 4'd4;
    localparam logic [3:0] OP_WRHS   = 4'd5;
    localparam logic [3:0] OP_RDH    = 4'd6;
    localparam logic [3:0] OP_TURN   = 4'd7;
    localparam logic [3:0] OP_MAGCMP = 4'd8;

    typedef struct packed {
        logic [3:0]    op;
        logic [CW-1:0] addr;
        logic [1:0]    slot;
        logic          wr_key;
        logic          clr_best;
        logic          upd_best;
    } t_cmd;

    typedef struct packed {
        logic less_y;
        logic goes_first;
        logic right_turn;
        logic mag_gt;
    } t_stat;

endpackage

FILE: rtl/ltch_datapath.sv
module ltch_datapath
    import ltch_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cmd        i_cmd,
    input  t_point      i_load_pt,
    output t_stat       o_stat,
    output logic [31:0] o_best
);

    // Point and hull memories, one port each used per cycle.
    t_point r_pmem [MAX_POINTS];
    t_point r_hmem [MAX_POINTS];
    t_point r_prd;
    t_point r_hrd;

    // Operand registers: slot 0..3 hold working points.
    t_point r_op [4];
    t_point r_key;
    logic signed [33:0] r_p1, r_p2;
    logic signed [34:0] r_cr;
    logic [34:0] r_magprev;
    logic [34:0] r_mag;
    logic [32:0] r_best;
    logic [33:0] r_d1, r_d2;

    logic [AW-1:0] w_a;
    t_point w_wr;
    assign w_a = i_cmd.addr[AW-1:0];
    assign w_wr = i_cmd.wr_key ? r_key : r_op[i_cmd.slot];

    always_ff @(posedge i_clk) begin
        if (i_cmd.op == OP_LOAD) r_pmem[w_a] <= i_load_pt;
        if (i_cmd.op == OP_WRPS) r_pmem[w_a] <= w_wr;
        if (i_cmd.op == OP_WRHS) r_hmem[w_a] <= w_wr;
        r_prd <= r_pmem[w_a];
        r_hrd <= r_hmem[w_a];
    end

    // Cross product pipeline: (op1-op0) x (op2-op0), and squared distances to op0.
    logic signed [16:0] w_ax, w_ay, w_bx, w_by;
    assign w_ax = 17'(r_op[1].x) - 17'(r_op[0].x);
    assign w_ay = 17'(r_op[1].y) - 17'(r_op[0].y);
    assign w_bx = 17'(r_op[2].x) - 17'(r_op[0].x);
    assign w_by = 17'(r_op[2].y) - 17'(r_op[0].y);

    logic [34:0] w_abs;
    assign w_abs = r_cr[34] ? 35'(-r_cr) : 35'(r_cr);

    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            OP_RDA:  r_op[i_cmd.slot] <= r_prd;
            OP_RDB:  r_key <= r_prd;
            OP_RDH:  r_op[i_cmd.slot] <= r_hrd;
            OP_TURN: begin
                r_p1 <= 34'(w_ax) * 34'(w_by);
                r_p2 <= 34'(w_ay) * 34'(w_bx);
                r_d1 <= 34'(w_ax * w_ax) + 34'(w_ay * w_ay);
                r_d2 <= 34'(w_bx * w_bx) + 34'(w_by * w_by);
            end
            OP_MAGCMP: begin
                r_magprev <= r_mag;
                r_mag <= w_abs;
            end
            default: begin
                if (i_cmd.wr_key && i_cmd.op == OP_NONE) r_op[i_cmd.slot] <= r_key;
            end
        endcase
        r_cr <= 35'(r_p1) - 35'(r_p2);
    end

    // Best area, cleared per set.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.clr_best) begin
            r_best <= '0;
        end else if (i_cmd.upd_best && {1'b0, r_mag} > 36'(r_best)) begin
            r_best <= r_mag[32:0];
        end
    end

    always_comb begin
        o_stat.less_y = (r_op[1].y < r_op[0].y) ||
                        (r_op[1].y == r_op[0].y && r_op[1].x < r_op[0].x);
        o_stat.right_turn = r_cr[34];
        o_stat.goes_first = (r_cr != '0) ? (r_cr > 0) : (r_d1 < r_d2);
        o_stat.mag_gt = r_mag > r_magprev;
    end
    assign o_best = r_best[31:0];

endmodule

FILE: rtl/ltch_ctrl.sv
module ltch_ctrl
    import ltch_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    input  logic        i_last_point,
    input  t_stat       i_stat,
    output t_cmd        o_cmd,
    output logic        busy,
    output logic        o_done,
    output logic        o_ovf
);

    localparam logic [5:0] S_IDLE  = 6'd0;
    localparam logic [5:0] S_PV_R0 = 6'd1;  // read point 0 into slot0 / best
    localparam logic [5:0] S_PV_R1 = 6'd2;
    localparam logic [5:0] S_PV_RI = 6'd3;
    localparam logic [5:0] S_PV_W  = 6'd4;
    localparam logic [5:0] S_PV_C  = 6'd5;
    localparam logic [5:0] S_SW_R0 = 6'd6;
    localparam logic [5:0] S_SW_R1 = 6'd7;
    localparam logic [5:0] S_SW_RL = 6'd8;
    localparam logic [5:0] S_SW_RW = 6'd9;
    localparam logic [5:0] S_SW_W0 = 6'd10;
    localparam logic [5:0] S_SW_WL = 6'd11;
    localparam logic [5:0] S_IS_RK = 6'd12;
    localparam logic [5:0] S_IS_WK = 6'd13;
    localparam logic [5:0] S_IS_RJ = 6'd14;
    localparam logic [5:0] S_IS_WJ = 6'd15;
    localparam logic [5:0] S_IS_T  = 6'd16;
    localparam logic [5:0] S_IS_T1 = 6'd17;
    localparam logic [5:0] S_IS_T2 = 6'd18;
    localparam logic [5:0] S_IS_D  = 6'd19;
    localparam logic [5:0] S_GS_RP = 6'd20;
    localparam logic [5:0] S_GS_WP = 6'd21;
    localparam logic [5:0] S_GS_RA = 6'd22;
    localparam logic [5:0] S_GS_WA = 6'd23;
    localparam logic [5:0] S_GS_RB = 6'd24;
    localparam logic [5:0] S_GS_WB = 6'd25;
    localparam logic [5:0] S_GS_T  = 6'd26;
    localparam logic [5:0] S_GS_T1 = 6'd27;
    localparam logic [5:0] S_GS_T2 = 6'd28;
    localparam logic [5:0] S_GS_D  = 6'd29;
    localparam logic [5:0] S_PR_BG = 6'd30;
    localparam logic [5:0] S_AR_BG = 6'd31;
    localparam logic [5:0] S_AR_R0 = 6'd32;
    localparam logic [5:0] S_AR_W0 = 6'd33;
    localparam logic [5:0] S_AR_R1 = 6'd34;
    localparam logic [5:0] S_AR_W1 = 6'd35;
    localparam logic [5:0] S_AR_R2 = 6'd36;
    localparam logic [5:0] S_AR_W2 = 6'd37;
    localparam logic [5:0] S_AR_T  = 6'd38;
    localparam logic [5:0] S_AR_T1 = 6'd39;
    localparam logic [5:0] S_AR_T2 = 6'd40;
    localparam logic [5:0] S_AR_M  = 6'd41;
    localparam logic [5:0] S_AR_D  = 6'd42;
    localparam logic [5:0] S_OUT   = 6'd43;

    logic [5:0]    r_st, n_st;
    logic [CW-1:0] r_cnt, n_cnt;
    logic [CW-1:0] r_n, n_n;
    logic [CW-1:0] r_i, n_i;
    logic [CW-1:0] r_j, n_j;
    logic [CW-1:0] r_lo, n_lo;
    logic [CW:0]   r_alo, n_alo;
    logic [CW:0]   r_ahi, n_ahi;
    logic [CW:0]   r_mid, n_mid;
    logic [CW:0]   r_abest, n_abest;
    logic [CW-1:0] r_hs, n_hs;
    logic          r_arc2, n_arc2;
    logic [1:0]    r_ph, n_ph;
    logic          r_ovf, n_ovf;
    logic          r_dn, n_dn;
    logic          r_oovf, n_oovf;

    // Hull index modulo hull size; value below twice the size.
    function automatic logic [CW-1:0] hmod(input logic [CW:0] k, input logic [CW-1:0] hs);
        logic [CW:0] t;
        t = k - {1'b0, hs};
        return (k >= {1'b0, hs}) ? t[CW-1:0] : k[CW-1:0];
    endfunction

    logic w_acc;
    assign w_acc = start && !busy;
    assign busy = (r_st != S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= S_IDLE; r_cnt <= '0; r_ovf <= 1'b0; r_dn <= 1'b0; r_oovf <= 1'b0;
            r_n <= '0; r_i <= '0; r_j <= '0; r_lo <= '0; r_hs <= '0;
            r_alo <= '0; r_ahi <= '0; r_mid <= '0; r_abest <= '0; r_arc2 <= 1'b0;
            r_ph <= '0;
        end else begin
            r_st <= n_st; r_cnt <= n_cnt; r_ovf <= n_ovf; r_dn <= n_dn; r_oovf <= n_oovf;
            r_n <= n_n; r_i <= n_i; r_j <= n_j; r_lo <= n_lo; r_hs <= n_hs;
            r_alo <= n_alo; r_ahi <= n_ahi; r_mid <= n_mid; r_abest <= n_abest;
            r_arc2 <= n_arc2; r_ph <= n_ph;
        end
    end

    always_comb begin
        n_st = r_st; n_cnt = r_cnt; n_ovf = r_ovf; n_dn = 1'b0; n_oovf = r_oovf;
        n_n = r_n; n_i = r_i; n_j = r_j; n_lo = r_lo; n_hs = r_hs;
        n_alo = r_alo; n_ahi = r_ahi; n_mid = r_mid; n_abest = r_abest;
        n_arc2 = r_arc2; n_ph = r_ph;
        o_cmd = '0;
        case (r_st)
            S_IDLE: begin
                if (w_acc) begin
                    if (r_cnt < CW'(MAX_POINTS)) begin
                        o_cmd.op = OP_LOAD;
                        o_cmd.addr = r_cnt;
                        n_cnt = r_cnt + 1'b1;
                    end else begin
                        n_ovf = 1'b1;
                    end
                    if (i_last_point) begin
                        n_n = (r_cnt < CW'(MAX_POINTS)) ? r_cnt + 1'b1 : r_cnt;
                        n_oovf = r_ovf || !(r_cnt < CW'(MAX_POINTS));
                        n_hs = '0;
                        n_st = S_PV_R0;
                    end
                end
            end
            // Pivot search: slot0 = current best, slot1 = candidate.
            S_PV_R0: begin
                o_cmd.clr_best = 1'b1;
                n_hs = '0;
                if (r_n == '0) n_st = S_OUT;
                else begin
                    o_cmd.addr = '0; n_lo = '0; n_i = CW'(1); n_st = S_PV_R1;
                end
            end
            S_PV_R1: begin o_cmd.op = OP_RDA; o_cmd.slot = 2'd0; n_st = S_PV_RI; end
            S_PV_RI: begin
                if (r_i >= r_n) n_st = S_SW_R0;
                else begin o_cmd.addr = r_i; n_st = S_PV_W; end
            end
            S_PV_W:  begin o_cmd.op = OP_RDA; o_cmd.slot = 2'd1; n_st = S_PV_C; end
            S_PV_C: begin
                if (i_stat.less_y) begin
                    n_lo = r_i; o_cmd.slot = 2'd0; o_cmd.addr = r_i;
                    n_st = S_PV_R1;
                end else n_st = S_PV_RI;
                n_i = r_i + 1'b1;
            end
            // Swap point 0 and the pivot entry: key = store[lo], slot3 = store[0].
            S_SW_R0: begin o_cmd.addr = '0; n_st = S_SW_R1; end
            S_SW_R1: begin o_cmd.op = OP_RDA; o_cmd.slot = 2'd3; o_cmd.addr = r_lo;
                n_st = S_SW_RL; end
            S_SW_RL: begin o_cmd.op = OP_RDB; n_st = S_SW_RW; end
            S_SW_RW: begin o_cmd.op = OP_WRPS; o_cmd.addr = r_lo; o_cmd.slot = 2'd3;
                n_st = S_SW_W0; end
            S_SW_W0: begin o_cmd.op = OP_WRPS; o_cmd.addr = '0; o_cmd.wr_key = 1'b1;
                n_st = S_SW_WL; end
            S_SW_WL: begin
                // Pivot into slot0 for the sort.
                o_cmd.wr_key = 1'b1; o_cmd.slot = 2'd0;
                n_i = CW'(2); n_st = S_IS_RK;
            end
            // Insertion sort with the pivot in slot0, key in slot1, probe in slot2.
            S_IS_RK: begin
                if (r_i >= r_n) begin n_i = '0; n_hs = '0; n_st = S_GS_RP; end
                else begin o_cmd.addr = r_i; n_j = r_i; n_st = S_IS_WK; end
            end
            S_IS_WK: begin o_cmd.op = OP_RDB; n_st = S_IS_RJ; end
            S_IS_RJ: begin
                o_cmd.wr_key = 1'b1; o_cmd.slot = 2'd1;
                if (r_j > CW'(1)) begin o_cmd.addr = r_j - 1'b1; n_st = S_IS_WJ; end
                else n_st = S_IS_D;
            end
            S_IS_WJ: begin o_cmd.op = OP_RDA; o_cmd.slot = 2'd2; n_st = S_IS_T; end
            S_IS_T:  begin o_cmd.op = OP_TURN; n_st = S_IS_T1; end
            S_IS_T1: n_st = S_IS_T2;
            S_IS_T2: begin
                if (i_stat.goes_first) begin
                    o_cmd.op = OP_WRPS; o_cmd.addr = r_j; o_cmd.slot = 2'd2;
                    n_j = r_j - 1'b1; n_st = S_IS_RJ;
                end else n_st = S_IS_D;
            end
            S_IS_D: begin
                o_cmd.op = OP_WRPS; o_cmd.addr = r_j; o_cmd.wr_key = 1'b1;
                n_i = r_i + 1'b1; n_st = S_IS_RK;
            end
            // Graham scan: slot0 = hull[hs-2], slot1 = hull[hs-1], slot2 = p[i].
            S_GS_RP: begin
                if (r_i >= r_n) n_st = S_PR_BG;
                else begin o_cmd.addr = r_i; n_st = S_GS_WP; end
            end
            S_GS_WP: begin o_cmd.op = OP_RDA; o_cmd.slot = 2'd2; n_st = S_GS_RA; end
            S_GS_RA: begin
                if (r_hs < CW'(2)) n_st = S_GS_D;
                else begin o_cmd.addr = r_hs - CW'(2); n_st = S_GS_WA; end
            end
            S_GS_WA: begin o_cmd.op = OP_RDH; o_cmd.slot = 2'd0;
                o_cmd.addr = r_hs - 1'b1; n_st = S_GS_WB; end
            S_GS_WB: begin o_cmd.op = OP_RDH; o_cmd.slot = 2'd1; n_st = S_GS_T; end
            S_GS_T:  begin o_cmd.op = OP_TURN; n_st = S_GS_T1; end
            S_GS_T1: n_st = S_GS_T2;
            S_GS_T2: begin
                if (i_stat.right_turn) begin n_hs = r_hs - 1'b1; n_st = S_GS_RA; end
                else n_st = S_GS_D;
            end
            S_GS_D: begin
                o_cmd.op = OP_WRHS; o_cmd.addr = r_hs; o_cmd.slot = 2'd2;
                n_hs = r_hs + 1'b1; n_i = r_i + 1'b1; n_st = S_GS_RP;
            end
            // Pair loop over hull indices.
            S_PR_BG: begin
                n_i = '0; n_j = CW'(1); n_arc2 = 1'b0; n_st = S_AR_BG;
            end
            S_AR_BG: begin
                if (r_i >= r_hs) n_st = S_OUT;
                else if (r_j >= r_hs) begin
                    n_i = r_i + 1'b1; n_j = r_i + CW'(2);
                end else begin
                    n_alo = r_arc2 ? {1'b0, r_j} + 1'b1 : {1'b0, r_i} + 1'b1;
                    n_ahi = r_arc2 ? {1'b0, r_i} + {1'b0, r_hs} : {1'b0, r_j};
                    n_abest = r_arc2 ? {1'b0, r_j} + 1'b1 : {1'b0, r_i} + 1'b1;
                    n_ph = 2'd0;
                    n_st = S_AR_R0;
                end
            end
            // Load a = hull[i], b = hull[j].
            S_AR_R0: begin o_cmd.addr = r_i; n_st = S_AR_W0; end
            S_AR_W0: begin o_cmd.op = OP_RDH; o_cmd.slot = 2'd0; o_cmd.addr = r_j;
                n_st = S_AR_W1; end
            S_AR_W1: begin o_cmd.op = OP_RDH; o_cmd.slot = 2'd1; n_st = S_AR_R1; end
            // Binary step: compare mag at mid-1 then mid.
            S_AR_R1: begin
                if (r_ph == 2'd2) begin
                    o_cmd.addr = hmod(r_abest, r_hs); n_st = S_AR_W2;
                end else if (r_alo > r_ahi) begin
                    n_ph = 2'd2; o_cmd.addr = hmod(r_abest, r_hs); n_st = S_AR_W2;
                end else begin
                    n_mid = (r_alo + r_ahi) >> 1;
                    o_cmd.addr = hmod(((r_alo + r_ahi) >> 1) - 1'b1, r_hs);
                    n_ph = 2'd0; n_st = S_AR_W2;
                end
            end
            S_AR_W2: begin o_cmd.op = OP_RDH; o_cmd.slot = 2'd2; n_st = S_AR_T; end
            S_AR_T:  begin o_cmd.op = OP_TURN; n_st = S_AR_T1; end
            S_AR_T1: n_st = S_AR_T2;
            S_AR_T2: begin o_cmd.op = OP_MAGCMP; n_st = S_AR_M; end
            S_AR_M: begin
                if (r_ph == 2'd2) begin
                    o_cmd.upd_best = 1'b1; n_st = S_AR_D;
                end else if (r_ph == 2'd0) begin
                    n_ph = 2'd1; o_cmd.addr = hmod(r_mid, r_hs); n_st = S_AR_W2;
                end else begin
                    if (i_stat.mag_gt) begin
                        n_abest = r_mid; n_alo = r_mid + 1'b1;
                    end else begin
                        n_ahi = r_mid - 1'b1;
                    end
                    if (!i_stat.mag_gt && r_mid == '0) n_ph = 2'd2;
                    else n_ph = 2'd0;
                    n_st = S_AR_R1;
                end
            end
            S_AR_D: begin
                if (r_arc2) begin n_arc2 = 1'b0; n_j = r_j + 1'b1; end
                else n_arc2 = 1'b1;
                n_st = S_AR_BG;
            end
            S_OUT: begin
                n_dn = 1'b1; n_cnt = '0; n_ovf = 1'b0; n_st = S_IDLE;
            end
            default: n_st = S_IDLE;
        endcase
    end

    assign o_done = r_dn;
    assign o_ovf = r_oovf;

`ifndef SYNTHESIS
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CW'(MAX_POINTS)) else $error("point count past capacity");
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_dn |-> r_st == S_IDLE) else $error("done outside idle");
    a_hs_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_hs <= r_n) else $error("hull larger than point set");
`endif

endmodule

FILE: rtl/largest_triangle_on_convex_hull_top.sv
// Points are loaded as words, one per cycle while busy is low and start is
// high; points beyond 1024 are dropped and flagged on o_too_many_points. The
// word with i_last_point set ends the set, and busy then stays high while the
// pivot search, the insertion sort, the Graham scan and the per-pair binary
// searches run one memory access at a time; a binary search runs for each of
// the h*(h-1) arcs of an h-point hull. The single result appears with o_valid,
// high for one cycle, in the same cycle in which busy falls; it cannot be
// stalled.
module largest_triangle_on_convex_hull_top
    import ltch_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [15:0] i_point_x,
    input  logic [15:0] i_point_y,
    input  logic        i_last_point,
    output logic        o_valid,
    output logic [31:0] o_twice_area,
    output logic        o_too_many_points
);

    t_cmd   w_cmd;
    t_stat  w_stat;
    t_point w_pt;

    assign w_pt.x = t_coord'(i_point_x);
    assign w_pt.y = t_coord'(i_point_y);

    ltch_ctrl u_ctrl (
        .i_clk, .i_rst_n, .start, .i_last_point,
        .i_stat(w_stat), .o_cmd(w_cmd), .busy,
        .o_done(o_valid), .o_ovf(o_too_many_points)
    );

    ltch_datapath u_dp (
        .i_clk, .i_rst_n, .i_cmd(w_cmd), .i_load_pt(w_pt),
        .o_stat(w_stat), .o_best(o_twice_area)
    );

endmodule
